### rtl/core/texaddr_pkg.sv
// shared types, codes and constants of the texel address generator
package texaddr_pkg;

    // number of register stages from request to result
    localparam int unsigned STAGES = 5;

    // width of a coordinate after scaling by the level size
    localparam int unsigned SCALE_W = 48;

    // half a texel in Q16
    localparam logic [SCALE_W-1:0] HALF_TEXEL = SCALE_W'(32768);

    // widest texel index inside one level
    localparam int unsigned IDX_W = 15;

    typedef enum logic [2:0] {
        FMT_CLUT8    = 3'd0,
        FMT_CLUT4    = 3'd1,
        FMT_RGB565   = 3'd2,
        FMT_ARGB1555 = 3'd3,
        FMT_ARGB4444 = 3'd4
    } fmt_t;

    typedef enum logic [1:0] {
        WRAP_REPEAT = 2'd0,
        WRAP_CLAMP  = 2'd1,
        WRAP_MIRROR = 2'd2
    } wrap_t;

    // one request beat as it arrives
    typedef struct packed {
        logic signed [31:0] coord_u;
        logic signed [31:0] coord_v;
        logic [7:0]         detail_level;
        logic [31:0]        texture_base;
        logic [31:0]        mode_word;
    } req_t;

    // per-request control carried down the pipe
    typedef struct packed {
        logic [31:0] base;
        logic [3:0]  lw;
        logic [3:0]  lh;
        logic [3:0]  level;
        logic [31:0] loff;
        logic [1:0]  wrap_u;
        logic [1:0]  wrap_v;
        logic        bil;
        logic        clut;
        logic        clut4;
        logic        is16;
        logic        err;
    } ctl_t;

    // after decode
    typedef struct packed {
        ctl_t               ctl;
        logic signed [31:0] coord_u;
        logic signed [31:0] coord_v;
    } s1_t;

    // after scaling
    typedef struct packed {
        ctl_t        ctl;
        logic [31:0] iu0;
        logic [31:0] iv0;
        logic [7:0]  fu;
        logic [7:0]  fv;
    } s2_t;

    // after wrapping
    typedef struct packed {
        ctl_t             ctl;
        logic [7:0]       fu;
        logic [7:0]       fv;
        logic [IDX_W-1:0] wu0;
        logic [IDX_W-1:0] wu1;
        logic [IDX_W-1:0] wv0;
        logic [IDX_W-1:0] wv1;
    } s3_t;

    // one result beat
    typedef struct packed {
        logic [31:0] tap_addr_0;
        logic [31:0] tap_addr_1;
        logic [31:0] tap_addr_2;
        logic [31:0] tap_addr_3;
        logic [7:0]  frac_u;
        logic [7:0]  frac_v;
        logic [3:0]  mip_level;
        logic        use_bilinear;
        logic        is_palette;
        logic        nibble_select;
        logic        byte_select;
        logic        mode_fault;
    } res_t;

endpackage

### rtl/core/texel_address_generator.sv
// top level of the texel address generator: pipeline control and stage hookup
// A beat passes the decode, scale, wrap, offset and address stage registers.
// Throughput: one request per cycle; stages holding no beat fill up behind a
// stalled output, so req_stall rises only when all five stages are occupied.
// Reset (rst_n low, asynchronous) empties every stage; no result is shown
// until a request is taken after reset.
module texel_address_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic signed [31:0] coord_u,
    input  logic signed [31:0] coord_v,
    input  logic [7:0]         detail_level,
    input  logic [31:0]        texture_base,
    input  logic [31:0]        mode_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [31:0]        tap_addr_0,
    output logic [31:0]        tap_addr_1,
    output logic [31:0]        tap_addr_2,
    output logic [31:0]        tap_addr_3,
    output logic [7:0]         frac_u,
    output logic [7:0]         frac_v,
    output logic [3:0]         mip_level,
    output logic               use_bilinear,
    output logic               is_palette,
    output logic               nibble_select,
    output logic               byte_select,
    output logic               mode_fault
);
    import texaddr_pkg::*;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] adv;
    req_t              req;
    s1_t               s1;
    s2_t               s2;
    s3_t               s3;
    res_t              res;

    // a stage moves when it is empty or the stage after it moves
    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || !rsp_stall;
        for (int i = STAGES-2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next[0] = adv[0] ? req_valid : valid_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            valid_next[i] = adv[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    // valid bits travel with the beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign req_stall = !adv[0];
    assign rsp_valid = valid_reg[STAGES-1];

    // request beat
    always_comb
    begin
        req.coord_u      = coord_u;
        req.coord_v      = coord_v;
        req.detail_level = detail_level;
        req.texture_base = texture_base;
        req.mode_word    = mode_word;
    end

    texaddr_decode u_decode (
        .clk  (clk),
        .load (adv[0]),
        .req  (req),
        .s1   (s1)
    );

    texaddr_scale u_scale (
        .clk  (clk),
        .load (adv[1]),
        .s1   (s1),
        .s2   (s2)
    );

    texaddr_wrap u_wrap (
        .clk  (clk),
        .load (adv[2]),
        .s2   (s2),
        .s3   (s3)
    );

    texaddr_addr u_addr (
        .clk        (clk),
        .load_total (adv[3]),
        .load_addr  (adv[4]),
        .s3         (s3),
        .res        (res)
    );

    // result beat
    assign tap_addr_0    = res.tap_addr_0;
    assign tap_addr_1    = res.tap_addr_1;
    assign tap_addr_2    = res.tap_addr_2;
    assign tap_addr_3    = res.tap_addr_3;
    assign frac_u        = res.frac_u;
    assign frac_v        = res.frac_v;
    assign mip_level     = res.mip_level;
    assign use_bilinear  = res.use_bilinear;
    assign is_palette    = res.is_palette;
    assign nibble_select = res.nibble_select;
    assign byte_select   = res.byte_select;
    assign mode_fault    = res.mode_fault;

endmodule

### rtl/core/texaddr_decode.sv
// stage one: mode word decode, mip level choice and level offset
module texaddr_decode (
    input  logic               clk,
    input  logic               load,
    input  texaddr_pkg::req_t  req,
    output texaddr_pkg::s1_t   s1
);
    import texaddr_pkg::*;

    s1_t        s1_reg;
    s1_t        s1_next;
    logic [2:0] fmt;
    logic       bil_req;
    logic [3:0] log2w;
    logic [3:0] log2h;
    logic [3:0] max_lvl;
    logic       mip_en;
    logic       clut;
    logic       is16;
    logic [3:0] chain;
    logic       lvl_over;
    logic [3:0] cap;
    logic [3:0] req_lvl;
    logic [3:0] level;
    logic [4:0] sum_lg;
    logic [5:0] diff;
    logic [31:0] loff;

    // unpack the mode word and work out level, sizes and error flags
    always_comb
    begin
        fmt     = req.mode_word[2:0];
        bil_req = req.mode_word[3];
        log2w   = req.mode_word[11:8];
        log2h   = req.mode_word[15:12];
        max_lvl = req.mode_word[19:16];
        mip_en  = req.mode_word[20];

        unique case (fmt) inside
            FMT_CLUT8, FMT_CLUT4:
            begin
                clut = 1'b1;
                is16 = 1'b0;
            end
            FMT_RGB565, FMT_ARGB1555, FMT_ARGB4444:
            begin
                clut = 1'b0;
                is16 = 1'b1;
            end
            default:
            begin
                clut = 1'b0;
                is16 = 1'b0;
            end
        endcase

        chain    = (log2w < log2h) ? log2w : log2h;
        lvl_over = max_lvl > chain;
        cap      = lvl_over ? chain : max_lvl;
        req_lvl  = mip_en ? req.detail_level[7:4] : 4'd0;
        level    = (req_lvl > cap) ? cap : req_lvl;

        // levels above this one occupy distinct powers of two, so each
        // offset bit is set on its own
        sum_lg = {1'b0, log2w} + {1'b0, log2h};
        diff   = '0;
        loff   = '0;
        for (int j = 0; j < 32; j++)
        begin
            diff    = {1'b0, sum_lg} - 6'(j);
            loff[j] = (6'(j) <= {1'b0, sum_lg}) && !diff[0]
                      && (diff[5:1] < {1'b0, level});
        end

        s1_next.ctl.base   = req.texture_base;
        s1_next.ctl.lw     = log2w - level;
        s1_next.ctl.lh     = log2h - level;
        s1_next.ctl.level  = level;
        s1_next.ctl.loff   = loff;
        s1_next.ctl.wrap_u = req.mode_word[5:4];
        s1_next.ctl.wrap_v = req.mode_word[7:6];
        s1_next.ctl.bil    = bil_req && !clut;
        s1_next.ctl.clut   = clut;
        s1_next.ctl.clut4  = (fmt == FMT_CLUT4);
        s1_next.ctl.is16   = is16;
        s1_next.ctl.err    = (bil_req && clut) || (|req.mode_word[31:21])
                             || lvl_over || (!clut && !is16);
        s1_next.coord_u    = req.coord_u;
        s1_next.coord_v    = req.coord_v;
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

### rtl/core/texaddr_scale.sv
// stage two: scale coordinates to the level, half-texel bias, split integer and fraction
module texaddr_scale (
    input  logic             clk,
    input  logic             load,
    input  texaddr_pkg::s1_t s1,
    output texaddr_pkg::s2_t s2
);
    import texaddr_pkg::*;

    s2_t                s2_reg;
    s2_t                s2_next;
    logic [SCALE_W-1:0] su;
    logic [SCALE_W-1:0] sv;
    logic [SCALE_W-1:0] bias;
    logic [SCALE_W-1:0] tu;
    logic [SCALE_W-1:0] tv;

    // sign-extend, shift by the level size, subtract the bias
    always_comb
    begin
        su   = {{(SCALE_W-32){s1.coord_u[31]}}, s1.coord_u};
        sv   = {{(SCALE_W-32){s1.coord_v[31]}}, s1.coord_v};
        bias = s1.ctl.bil ? HALF_TEXEL : '0;
        tu   = (su << s1.ctl.lw) - bias;
        tv   = (sv << s1.ctl.lh) - bias;

        s2_next.ctl = s1.ctl;
        s2_next.iu0 = tu[47:16];
        s2_next.iv0 = tv[47:16];
        s2_next.fu  = s1.ctl.bil ? tu[15:8] : 8'd0;
        s2_next.fv  = s1.ctl.bil ? tv[15:8] : 8'd0;
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

### rtl/core/texaddr_wrap.sv
// stage three: repeat, clamp or mirror of both texel columns and rows
module texaddr_wrap (
    input  logic             clk,
    input  logic             load,
    input  texaddr_pkg::s2_t s2,
    output texaddr_pkg::s3_t s3
);
    import texaddr_pkg::*;

    s3_t         s3_reg;
    s3_t         s3_next;
    logic [31:0] iu1;
    logic [31:0] iv1;

    // fold a two's-complement index into one level of 2^lg texels
    function automatic logic [IDX_W-1:0] wrap_idx(
        input logic [31:0] t,
        input logic [1:0]  mode,
        input logic [3:0]  lg
    );
        logic [IDX_W:0]   mask_w;
        logic [IDX_W-1:0] mask;
        logic [IDX_W:0]   low_bits;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] r;
        mask_w   = ((IDX_W+1)'(1) << lg) - (IDX_W+1)'(1);
        mask     = mask_w[IDX_W-1:0];
        low_bits = t[IDX_W:0];
        lo       = t[IDX_W-1:0] & mask;
        case (mode)
            WRAP_REPEAT: r = lo;
            WRAP_CLAMP:
            begin
                if (t[31])
                    r = '0;
                else if (t > 32'(mask))
                    r = mask;
                else
                    r = t[IDX_W-1:0];
            end
            WRAP_MIRROR: r = low_bits[lg] ? (~lo & mask) : lo;
            default:     r = lo;
        endcase
        return r;
    endfunction

    // neighbour indices and their wrapped forms
    always_comb
    begin
        iu1 = s2.iu0 + 32'd1;
        iv1 = s2.iv0 + 32'd1;

        s3_next.ctl = s2.ctl;
        s3_next.fu  = s2.fu;
        s3_next.fv  = s2.fv;
        s3_next.wu0 = wrap_idx(s2.iu0, s2.ctl.wrap_u, s2.ctl.lw);
        s3_next.wu1 = wrap_idx(iu1,    s2.ctl.wrap_u, s2.ctl.lw);
        s3_next.wv0 = wrap_idx(s2.iv0, s2.ctl.wrap_v, s2.ctl.lh);
        s3_next.wv1 = wrap_idx(iv1,    s2.ctl.wrap_v, s2.ctl.lh);
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s3_reg <= s3_next;
        end
    end

    assign s3 = s3_reg;

endmodule

### rtl/core/texaddr_addr.sv
// stages four and five: texel offsets within the chain, then byte addresses
module texaddr_addr (
    input  logic             clk,
    input  logic             load_total,
    input  logic             load_addr,
    input  texaddr_pkg::s3_t s3,
    output texaddr_pkg::res_t res
);
    import texaddr_pkg::*;

    logic [31:0] total_reg [4];
    logic [31:0] total_next [4];
    ctl_t        ctl_reg;
    logic [7:0]  fu_reg;
    logic [7:0]  fv_reg;
    logic [31:0] bytes [4];
    logic [31:0] addr [4];
    res_t        res_reg;
    res_t        res_next;

    // row-major texel offset of each tap, level offset added in
    always_comb
    begin
        total_next[0] = s3.ctl.loff + (32'(s3.wv0) << s3.ctl.lw) + 32'(s3.wu0);
        total_next[1] = s3.ctl.loff + (32'(s3.wv0) << s3.ctl.lw) + 32'(s3.wu1);
        total_next[2] = s3.ctl.loff + (32'(s3.wv1) << s3.ctl.lw) + 32'(s3.wu0);
        total_next[3] = s3.ctl.loff + (32'(s3.wv1) << s3.ctl.lw) + 32'(s3.wu1);
    end

    always_ff @(posedge clk)
    begin
        if (load_total)
        begin
            total_reg <= total_next;
            ctl_reg   <= s3.ctl;
            fu_reg    <= s3.fu;
            fv_reg    <= s3.fv;
        end
    end

    // texel size scaling and base add
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (ctl_reg.is16)
                bytes[k] = {total_reg[k][30:0], 1'b0};
            else if (ctl_reg.clut4)
                bytes[k] = {1'b0, total_reg[k][31:1]};
            else
                bytes[k] = total_reg[k];
            addr[k] = ctl_reg.base + bytes[k];
        end

        res_next.tap_addr_0    = addr[0];
        res_next.tap_addr_1    = addr[1];
        res_next.tap_addr_2    = addr[2];
        res_next.tap_addr_3    = addr[3];
        res_next.frac_u        = fu_reg;
        res_next.frac_v        = fv_reg;
        res_next.mip_level     = ctl_reg.level;
        res_next.use_bilinear  = ctl_reg.bil;
        res_next.is_palette    = ctl_reg.clut;
        res_next.nibble_select = total_reg[0][0];
        res_next.byte_select   = addr[0][0];
        res_next.mode_fault    = ctl_reg.err;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (load_addr)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### rtl/core/texaddr_checker.sv
// port-level checks of the texel address generator and their binding
module texaddr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic [31:0]        tap_addr_0,
    input logic [31:0]        tap_addr_3,
    input logic [7:0]         frac_u,
    input logic [7:0]         frac_v,
    input logic [3:0]         mip_level,
    input logic               use_bilinear,
    input logic               is_palette,
    input logic               mode_fault
);

    // a stalled result beat stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps tap addresses 0 and 3, mip level, u fraction and fault flag
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(tap_addr_0) && $stable(tap_addr_3)
            && $stable(mip_level) && $stable(frac_u) && $stable(mode_fault))
        else $error("result payload changed while stalled");

    // palette formats never filter
    a_palette_nearest: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_palette |-> !use_bilinear)
        else $error("bilinear reported on a palette format");

    // nearest sampling carries no blend fraction
    a_nearest_frac: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !use_bilinear |-> frac_u == 8'd0 && frac_v == 8'd0)
        else $error("fraction nonzero under nearest");

endmodule

bind texel_address_generator texaddr_checker u_texaddr_checker (.*);
